>>> hdl/assert_macros.svh
// Assertion helpers shared by the glyph rasterizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> hdl/g57_pkg.sv
package g57_pkg;

	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_ROWS = 7;
	localparam int CELL_COLS  = 6;
	localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;
	localparam int CELL_BITS  = CELL_COLS * GLYPH_ROWS;
	localparam int FIFO_DEPTH = 2;

	localparam logic [7:0] GLYPH_FIRST = 8'd32;
	localparam logic [7:0] GLYPH_LAST  = 8'd126;

	// Register index, taken from byte address bit 2.
	localparam logic REG_SCREEN_BG = 1'b0;

	// One classified character waiting for the rasterizer.
	typedef struct packed {
		logic [GLYPH_BITS-1:0] glyph;
		logic [7:0]            origin_x;
		logic [7:0]            origin_y;
		logic [15:0]           fg_color;
		logic [15:0]           bg_color;
	} glyph_entry_t;

	// Packs five column bytes, column 0 in the low bits, row 0 lowest.
	function automatic logic [GLYPH_BITS-1:0] cols(input logic [7:0] c0, input logic [7:0] c1,
		input logic [7:0] c2, input logic [7:0] c3, input logic [7:0] c4);
		return {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
	endfunction

	// Font ROM for the printable range; other codes read as blank.
	function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [7:0] code);
		logic [GLYPH_BITS-1:0] g;
		case (code)
			8'd32:  g = cols(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			8'd33:  g = cols(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
			8'd34:  g = cols(8'h00, 8'h07, 8'h00, 8'h07, 8'h00);
			8'd35:  g = cols(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14);
			8'd36:  g = cols(8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12);
			8'd37:  g = cols(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
			8'd38:  g = cols(8'h36, 8'h49, 8'h55, 8'h22, 8'h50);
			8'd39:  g = cols(8'h00, 8'h05, 8'h03, 8'h00, 8'h00);
			8'd40:  g = cols(8'h00, 8'h1C, 8'h22, 8'h41, 8'h00);
			8'd41:  g = cols(8'h00, 8'h41, 8'h22, 8'h1C, 8'h00);
			8'd42:  g = cols(8'h08, 8'h2A, 8'h1C, 8'h2A, 8'h08);
			8'd43:  g = cols(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
			8'd44:  g = cols(8'h00, 8'h50, 8'h30, 8'h00, 8'h00);
			8'd45:  g = cols(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
			8'd46:  g = cols(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
			8'd47:  g = cols(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
			8'd48:  g = cols(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
			8'd49:  g = cols(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
			8'd50:  g = cols(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
			8'd51:  g = cols(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
			8'd52:  g = cols(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
			8'd53:  g = cols(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
			8'd54:  g = cols(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
			8'd55:  g = cols(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
			8'd56:  g = cols(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
			8'd57:  g = cols(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
			8'd58:  g = cols(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
			8'd59:  g = cols(8'h00, 8'h56, 8'h36, 8'h00, 8'h00);
			8'd60:  g = cols(8'h00, 8'h08, 8'h14, 8'h22, 8'h41);
			8'd61:  g = cols(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
			8'd62:  g = cols(8'h41, 8'h22, 8'h14, 8'h08, 8'h00);
			8'd63:  g = cols(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
			8'd64:  g = cols(8'h32, 8'h49, 8'h79, 8'h41, 8'h3E);
			8'd65:  g = cols(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
			8'd66:  g = cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
			8'd67:  g = cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
			8'd68:  g = cols(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
			8'd69:  g = cols(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
			8'd70:  g = cols(8'h7F, 8'h09, 8'h09, 8'h01, 8'h01);
			8'd71:  g = cols(8'h3E, 8'h41, 8'h41, 8'h51, 8'h32);
			8'd72:  g = cols(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
			8'd73:  g = cols(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
			8'd74:  g = cols(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
			8'd75:  g = cols(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
			8'd76:  g = cols(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
			8'd77:  g = cols(8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F);
			8'd78:  g = cols(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
			8'd79:  g = cols(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
			8'd80:  g = cols(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
			8'd81:  g = cols(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
			8'd82:  g = cols(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
			8'd83:  g = cols(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
			8'd84:  g = cols(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
			8'd85:  g = cols(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
			8'd86:  g = cols(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
			8'd87:  g = cols(8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F);
			8'd88:  g = cols(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
			8'd89:  g = cols(8'h03, 8'h04, 8'h78, 8'h04, 8'h03);
			8'd90:  g = cols(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
			8'd91:  g = cols(8'h00, 8'h00, 8'h7F, 8'h41, 8'h41);
			8'd92:  g = cols(8'h02, 8'h04, 8'h08, 8'h10, 8'h20);
			8'd93:  g = cols(8'h41, 8'h41, 8'h7F, 8'h00, 8'h00);
			8'd94:  g = cols(8'h04, 8'h02, 8'h01, 8'h02, 8'h04);
			8'd95:  g = cols(8'h40, 8'h40, 8'h40, 8'h40, 8'h40);
			8'd96:  g = cols(8'h00, 8'h01, 8'h02, 8'h04, 8'h00);
			8'd97:  g = cols(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
			8'd98:  g = cols(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
			8'd99:  g = cols(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
			8'd100: g = cols(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
			8'd101: g = cols(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
			8'd102: g = cols(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
			8'd103: g = cols(8'h08, 8'h14, 8'h54, 8'h54, 8'h3C);
			8'd104: g = cols(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
			8'd105: g = cols(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
			8'd106: g = cols(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00);
			8'd107: g = cols(8'h00, 8'h7F, 8'h10, 8'h28, 8'h44);
			8'd108: g = cols(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
			8'd109: g = cols(8'h7C, 8'h04, 8'h18, 8'h04, 8'h78);
			8'd110: g = cols(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
			8'd111: g = cols(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
			8'd112: g = cols(8'h7C, 8'h14, 8'h14, 8'h14, 8'h08);
			8'd113: g = cols(8'h08, 8'h14, 8'h14, 8'h18, 8'h7C);
			8'd114: g = cols(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
			8'd115: g = cols(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
			8'd116: g = cols(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20);
			8'd117: g = cols(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
			8'd118: g = cols(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
			8'd119: g = cols(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
			8'd120: g = cols(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
			8'd121: g = cols(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C);
			8'd122: g = cols(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
			8'd123: g = cols(8'h00, 8'h08, 8'h36, 8'h41, 8'h00);
			8'd124: g = cols(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);
			8'd125: g = cols(8'h00, 8'h41, 8'h36, 8'h08, 8'h00);
			8'd126: g = cols(8'h08, 8'h08, 8'h2A, 8'h1C, 8'h08);
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

>>> hdl/g57_front.sv
module g57_front (
	input  logic                  push,
	output logic                  full,
	input  logic [7:0]            char_code,
	input  logic [7:0]            origin_x,
	input  logic [7:0]            origin_y,
	input  logic [15:0]           fg_color,
	input  logic [15:0]           bg_color,
	input  logic                  transparent,
	input  logic [15:0]           screen_bg,
	input  logic                  q_full,
	output logic                  q_wr,
	output g57_pkg::glyph_entry_t q_entry
);
	import g57_pkg::*;

	logic printable;

	// Only printable codes go on to the rasterizer; others are dropped here.
	assign printable = (char_code >= GLYPH_FIRST) && (char_code <= GLYPH_LAST);
	assign full      = q_full;
	assign q_wr      = push && !q_full && printable;

	// Glyph lookup and background selection for the queued entry.
	always_comb begin
		q_entry.glyph    = font_glyph(char_code);
		q_entry.origin_x = origin_x;
		q_entry.origin_y = origin_y;
		q_entry.fg_color = fg_color;
		q_entry.bg_color = transparent ? screen_bg : bg_color;
	end

endmodule

>>> hdl/g57_fifo.sv
`include "assert_macros.svh"

module g57_fifo #(
	parameter int DEPTH = g57_pkg::FIFO_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  g57_pkg::glyph_entry_t wr_data,
	output logic                  full,
	input  logic                  rd_en,
	output g57_pkg::glyph_entry_t rd_data,
	output logic                  empty
);
	import g57_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	glyph_entry_t       mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(wr_en && full && !rd_en), "write into full queue")
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, !(rd_en && empty), "read from empty queue")

endmodule

>>> hdl/g57_raster.sv
`include "assert_macros.svh"

module g57_raster (
	input  logic                  clk,
	input  logic                  arst_n,
	input  g57_pkg::glyph_entry_t head,
	input  logic                  q_empty,
	output logic                  q_rd,
	output logic                  empty,
	input  logic                  pop,
	output logic [7:0]            pixel_x,
	output logic [7:0]            pixel_y,
	output logic [15:0]           pixel_color,
	output logic                  last
);
	import g57_pkg::*;

	logic [2:0]           col_q;
	logic [2:0]           row_q;
	logic                 valid_q;
	logic [7:0]           pixel_x_q;
	logic [7:0]           pixel_y_q;
	logic [15:0]          pixel_color_q;
	logic                 last_q;
	logic                 advance;
	logic                 col_end;
	logic                 cell_end;
	logic [CELL_BITS-1:0] cell_bits;
	logic [5:0]           bit_idx;

	// A new pixel is made whenever a queue entry waits and the output register is free or being emptied.
	assign advance  = !q_empty && (!valid_q || pop);
	assign col_end  = (row_q == 3'(GLYPH_ROWS - 1));
	assign cell_end = col_end && (col_q == 3'(CELL_COLS - 1));
	assign q_rd     = advance && cell_end;

	// The spacing column reads as clear bits beyond the glyph.
	assign cell_bits = {{(CELL_BITS - GLYPH_BITS){1'b0}}, head.glyph};
	assign bit_idx   = 6'({3'b000, col_q} * 6'(GLYPH_ROWS)) + {3'b000, row_q};

	// Column and row walk over the cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				if (col_end) begin
					row_q <= '0;
					col_q <= cell_end ? '0 : col_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output pixel register.
	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_x_q     <= head.origin_x + {5'b00000, col_q};
			pixel_y_q     <= head.origin_y + {5'b00000, row_q};
			pixel_color_q <= cell_bits[bit_idx] ? head.fg_color : head.bg_color;
			last_q        <= cell_end;
		end
	end

	assign empty       = !valid_q;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last        = last_q;

	`ASSERT_ALWAYS(a_walk_range, clk, arst_n, (col_q < 3'(CELL_COLS)) && (row_q < 3'(GLYPH_ROWS)), "cell walk out of range")
	`ASSERT_NEXT(a_release_last, clk, arst_n, q_rd, valid_q && last_q, "entry released without last beat")

endmodule

>>> hdl/glyph_5x7_rasterizer_core.sv
// The character beat is written into the queue, and its first pixel beat is then loaded from the
// queue head into the output pixel register.
// One pixel beat per cycle while entries wait and pop keeps up; 42 beats per printable character.
// Unprintable codes are dropped at the input and give no beats.
// Reset (arst_n low, asynchronous) empties the queue, clears the walk and sets the
// screen background register to zero.
module glyph_5x7_rasterizer_core #(
	parameter int FIFO_DEPTH = g57_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic [7:0]  origin_x,
	input  logic [7:0]  origin_y,
	input  logic [15:0] fg_color,
	input  logic [15:0] bg_color,
	input  logic        transparent,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [15:0] pixel_color,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import g57_pkg::*;

	logic         cfg_wr;
	logic [15:0]  screen_bg_q;
	logic         q_wr;
	logic         q_rd;
	logic         q_full;
	logic         q_empty;
	glyph_entry_t q_wr_data;
	glyph_entry_t q_head;

	// Configuration register, written in the access cycle.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_bg_q <= '0;
		end else if (cfg_wr && (paddr[2] == REG_SCREEN_BG)) begin
			screen_bg_q <= pwdata[15:0];
		end
	end

	assign prdata = (paddr[2] == REG_SCREEN_BG) ? {16'h0000, screen_bg_q} : '0;

	g57_front u_front (
		.push        (push),
		.full        (full),
		.char_code   (char_code),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.fg_color    (fg_color),
		.bg_color    (bg_color),
		.transparent (transparent),
		.screen_bg   (screen_bg_q),
		.q_full      (q_full),
		.q_wr        (q_wr),
		.q_entry     (q_wr_data)
	);

	g57_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_wr),
		.wr_data (q_wr_data),
		.full    (q_full),
		.rd_en   (q_rd),
		.rd_data (q_head),
		.empty   (q_empty)
	);

	g57_raster u_raster (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.q_empty     (q_empty),
		.q_rd        (q_rd),
		.empty       (empty),
		.pop         (pop),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_color (pixel_color),
		.last        (last)
	);

endmodule
